// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// implication checked at every clock edge, reset included
`define ASSERT_IMPL(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)

`define ASSERT_IMPL(label, clk, prop)

`endif

`endif

// ===== src/adb_pkg.sv =====
// ----------------------------------------------------------------------------
// adb_pkg
// Types, constants and filter tables of the ADPCM block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adb_pkg;

   localparam int VOICE_SLOTS_DEFAULT = 48;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 8;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + 2;

   localparam logic [2:0] LAST_POS    = 3'd7;
   localparam logic [3:0] MAX_FILTER  = 4'd4;
   localparam logic [1:0] LAST_NIBBLE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_MUL_A,
      ST_MUL_B,
      ST_EMIT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [15:0] hist_one;
      logic [15:0] hist_two;
      logic [3:0]  shift;
      logic [2:0]  filter;
      logic [7:0]  flags;
      logic [2:0]  pos;
   } entry_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic sel_b;
   } mac_ctl_type;

   function automatic logic signed [COEF_W-1:0] coef_a(input logic [2:0] f);
      logic signed [COEF_W-1:0] c;
      case (f)
         3'd1:    c = 8'sd60;
         3'd2:    c = 8'sd115;
         3'd3:    c = 8'sd98;
         3'd4:    c = 8'sd122;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_b(input logic [2:0] f);
      logic signed [COEF_W-1:0] c;
      case (f)
         3'd2:    c = -8'sd52;
         3'd3:    c = -8'sd55;
         3'd4:    c = -8'sd60;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

endpackage

// ===== src/adb_ram.sv =====
// ----------------------------------------------------------------------------
// adb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/adb_mac.sv =====
// ----------------------------------------------------------------------------
// adb_mac
// Shared coefficient multiply-accumulate and sample finishing (round,
// nibble term, clamp).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adb_mac (
   input  logic                      clock,
   input  adb_pkg::mac_ctl_type      ctl,
   input  logic [2:0]                filter,
   input  logic [15:0]               hist_one,
   input  logic [15:0]               hist_two,
   input  logic [3:0]                nibble,
   input  logic [3:0]                shift,
   output logic signed [15:0]        sample
);

   import adb_pkg::*;

   logic signed [COEF_W-1:0]   mul_coef;
   logic signed [SAMPLE_W-1:0] mul_hist;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [ACC_W-1:0]    rounded;
   logic signed [SAMPLE_W-1:0] nib_term;
   logic signed [ACC_W-1:0]    total;

   always_comb begin
      mul_coef = ctl.sel_b ? coef_b(filter) : coef_a(filter);
      mul_hist = ctl.sel_b ? $signed(hist_two) : $signed(hist_one);
      prod     = PROD_W'(mul_coef * mul_hist);
      acc_in   = (ctl.clear ? ACC_W'(0) : acc_ff) + ACC_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      rounded  = (acc_ff + ACC_W'(32)) >>> 6;
      nib_term = $signed({nibble, 12'h000}) >>> shift;
      total    = rounded + ACC_W'(nib_term);
      if (total < -ACC_W'(32768)) begin
         sample = 16'sh8000;
      end else if (total > ACC_W'(32767)) begin
         sample = 16'sh7fff;
      end else begin
         sample = total[15:0];
      end
   end

endmodule

// ===== src/adb_decoder_top.sv =====
// ----------------------------------------------------------------------------
// adpcm_block_decoder
// Per-voice ADPCM block decoder: header words set shift, filter and flags,
// data words give four PCM samples each.
// ----------------------------------------------------------------------------
// One transaction at a time. A header word goes from acceptance to the
// next acceptance through accept, state read, load and state write. A data
// word goes through state read and load, then for each sample the steps on
// the single shared multiplier (feedback term, history term, finish and
// output), then the state write; output waits while the result channel is
// stalled. Voices at or above VOICE_SLOTS are accepted and dropped in idle.
// Per-voice state lives in one RAM with a valid bit per voice, so reset
// and restart take effect at once without a clearing pass.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module adpcm_block_decoder #(
   parameter int VOICE_SLOTS = adb_pkg::VOICE_SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [5:0]         req_voice,
   input  logic               req_restart,
   input  logic [15:0]        req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic [7:0]         rsp_loop_flags,
   output logic               rsp_last
);

   import adb_pkg::*;

   localparam int AW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;

   state_type state_ff, state_in;

   logic [AW-1:0]    voice_ff;
   logic             restart_ff;
   logic [15:0]      word_ff;
   logic [VOICE_SLOTS-1:0] valid_ff;

   logic [15:0] h1_ff, h2_ff;
   logic [3:0]  shift_ff;
   logic [2:0]  filt_ff;
   logic [7:0]  flags_ff;
   logic [2:0]  pos_ff;
   logic [1:0]  k_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff;
   logic [7:0]         rsp_flags_ff;
   logic               rsp_last_ff;

   logic        req_accept, in_range, out_free, load_out;
   logic        ram_rd_en, ram_wr_en;
   entry_type   rd_entry, wr_entry, cur_entry;
   mac_ctl_type mac_ctl;
   logic signed [15:0] sample;
   logic [3:0]  nibble;

   assign req_accept = req_valid && !req_stall;
   assign in_range   = {1'b0, req_voice} < 7'(VOICE_SLOTS);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign nibble     = word_ff[{k_ff, 2'b00} +: 4];

   adb_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(VOICE_SLOTS)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(voice_ff),
      .wr_data(wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(voice_ff),
      .rd_data(rd_entry)
   );

   adb_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .filter  (filt_ff),
      .hist_one(h1_ff),
      .hist_two(h2_ff),
      .nibble  (nibble),
      .shift   (shift_ff),
      .sample  (sample)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && in_range) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = (cur_entry.pos == 3'd0) ? ST_WRITE : ST_MUL_A;
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = (k_ff == LAST_NIBBLE) ? ST_WRITE : ST_MUL_A;
         end
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = 1'b1;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      load_out      = 1'b0;
      mac_ctl.load  = 1'b0;
      mac_ctl.clear = 1'b0;
      mac_ctl.sel_b = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_READ:  ram_rd_en = 1'b1;
         ST_MUL_A: begin
            mac_ctl.load  = 1'b1;
            mac_ctl.clear = 1'b1;
         end
         ST_MUL_B: begin
            mac_ctl.load  = 1'b1;
            mac_ctl.sel_b = 1'b1;
         end
         ST_EMIT:  load_out  = out_free;
         ST_WRITE: ram_wr_en = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   // stored entry with valid bit and restart applied
   always_comb begin
      cur_entry = valid_ff[voice_ff] ? rd_entry : '0;
      if (restart_ff) begin
         cur_entry.hist_one = '0;
         cur_entry.hist_two = '0;
         cur_entry.pos      = 3'd0;
      end
   end

   always_comb begin
      wr_entry.hist_one = h1_ff;
      wr_entry.hist_two = h2_ff;
      wr_entry.shift    = shift_ff;
      wr_entry.filter   = filt_ff;
      wr_entry.flags    = flags_ff;
      wr_entry.pos      = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (ram_wr_en) begin
            valid_ff[voice_ff] <= 1'b1;
         end
         if (load_out) begin
            k_ff <= k_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         voice_ff   <= req_voice[AW-1:0];
         restart_ff <= req_restart;
         word_ff    <= req_word;
      end
      if (state_ff == ST_LOAD) begin
         h1_ff <= cur_entry.hist_one;
         h2_ff <= cur_entry.hist_two;
         if (cur_entry.pos == 3'd0) begin
            shift_ff <= word_ff[3:0];
            filt_ff  <= (word_ff[7:4] <= MAX_FILTER) ? word_ff[6:4] : 3'd0;
            flags_ff <= word_ff[15:8];
            pos_ff   <= 3'd1;
         end else begin
            shift_ff <= cur_entry.shift;
            filt_ff  <= cur_entry.filter;
            flags_ff <= cur_entry.flags;
            pos_ff   <= cur_entry.pos;
         end
      end
      if (load_out) begin
         h2_ff <= h1_ff;
         h1_ff <= sample;
         if (k_ff == LAST_NIBBLE) begin
            pos_ff <= (pos_ff >= LAST_POS) ? 3'd0 : pos_ff + 3'd1;
         end
      end
   end

   // result register
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_sample_ff <= sample;
         rsp_flags_ff  <= flags_ff;
         rsp_last_ff   <= (k_ff == LAST_NIBBLE);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_loop_flags = rsp_flags_ff;
   assign rsp_last       = rsp_last_ff;

   `ASSERT_ALWAYS(a_accept_reads, clock, reset, (req_accept && in_range) |=> (state_ff == ST_READ))
   `ASSERT_ALWAYS(a_idle_k_zero, clock, reset, (state_ff == ST_IDLE) |-> (k_ff == 2'd0))
   `ASSERT_ALWAYS(a_load_after_read, clock, reset, (state_ff == ST_LOAD) |-> ($past(state_ff) == ST_READ))
   `ASSERT_ALWAYS(a_last_on_fourth, clock, reset, load_out |=> (rsp_last == ($past(k_ff) == LAST_NIBBLE)))

endmodule
